[sv/itsm_pkg.sv]
`timescale 1ns / 1ps
// Package for the tagged integer stack machine: words, tags, status codes,
// controller and arithmetic unit state types, and the control/status structs.
// Depends on nothing.
package itsm_pkg;

  typedef enum logic [3:0] {
    ACT_PUSH  = 4'd0,
    ACT_DEL   = 4'd1,
    ACT_DUP   = 4'd2,
    ACT_UNDER = 4'd3,
    ACT_GET   = 4'd4,
    ACT_SWAP  = 4'd5,
    ACT_ADD   = 4'd6,
    ACT_SUB   = 4'd7,
    ACT_MUL   = 4'd8,
    ACT_DIV   = 4'd9,
    ACT_MOD   = 4'd10,
    ACT_POW   = 4'd11,
    ACT_EQ    = 4'd12
  } action_e;

  localparam logic [1:0] TAG_NONE = 2'd0;
  localparam logic [1:0] TAG_WALL = 2'd1;
  localparam logic [1:0] TAG_INT  = 2'd2;
  localparam logic [1:0] TAG_BOOL = 2'd3;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_TYPE  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_INDEX = 3'd4;
  localparam logic [2:0] ST_OVER  = 3'd5;

  localparam int EntryW = 66;  // {tag, value}

  typedef enum logic [3:0] {
    S_IDLE, S_RDB, S_RDA, S_CAPA, S_DEC, S_GRD, S_GLD,
    S_ALU, S_WR1, S_WR2, S_TRD, S_TCAP
  } ctrl_state_e;

  typedef enum logic [2:0] {
    AL_IDLE, AL_MUL, AL_DIV, AL_PBIT, AL_PMUL, AL_PSQ, AL_FIN
  } alu_state_e;

  typedef enum logic [1:0] {AO_MUL, AO_DIV, AO_MOD, AO_POW} alu_op_e;

  typedef enum logic [1:0] {RS_TOP, RS_SECOND, RS_POS} rsel_e;

  typedef enum logic [1:0] {K_PLAIN, K_GET, K_ALU} kind_e;

  typedef struct packed {
    logic  latch_in;
    logic  cap_b;
    logic  cap_a;
    logic  decide;
    rsel_e rsel;
    logic  get_load;
    logic  alu_start;
    logic  alu_load;
    logic  wr1;
    logic  wr2;
    logic  commit;
    logic  out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  alu_done;
    logic  out_busy;
  } sts_t;

  function automatic logic [63:0] mag(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

[sv/itsm_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module itsm_ram #(
  parameter int WIDTH = 66,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[sv/itsm_alu.sv]
`timescale 1ns / 1ps
// Iterative arithmetic unit: 64-bit wrapping multiply from 32x32 partial products,
// restoring divide/remainder one bit per cycle, square-and-multiply power.
// Depends on itsm_pkg.
module itsm_alu
  import itsm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  alu_op_e     op_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [63:0] result_o
);

  alu_state_e state_q, state_d;
  logic [63:0] mx_q, my_q, prod_q, acc_q, r_q, sq_q, e_q, rem_q, quo_q, res_q;
  logic [1:0]  ph_q;
  logic [5:0]  dcnt_q;
  logic        neg_q, is_mod_q;

  logic [31:0] mul_x, mul_y;
  logic [63:0] prod_d, mul_res;
  logic [64:0] shl;
  logic        ge;
  logic [63:0] rem_n, quo_n;

  assign mul_x   = (ph_q == 2'd2) ? mx_q[63:32] : mx_q[31:0];
  assign mul_y   = (ph_q == 2'd1) ? my_q[63:32] : my_q[31:0];
  assign prod_d  = mul_x * mul_y;
  assign mul_res = acc_q + {prod_q[31:0], 32'd0};

  assign shl   = {rem_q, quo_q[63]};
  assign ge    = shl >= {1'b0, my_q};
  assign rem_n = ge ? 64'(shl - {1'b0, my_q}) : shl[63:0];
  assign quo_n = {quo_q[62:0], ge};

  always_comb begin
    state_d = state_q;
    case (state_q)
      AL_IDLE: begin
        if (start_i) begin
          case (op_i)
            AO_MUL:  state_d = AL_MUL;
            AO_DIV:  state_d = AL_DIV;
            AO_MOD:  state_d = AL_DIV;
            AO_POW:  state_d = b_i[63] ? AL_FIN : AL_PBIT;
            default: state_d = AL_FIN;
          endcase
        end
      end
      AL_MUL:  if (ph_q == 2'd3) state_d = AL_FIN;
      AL_DIV:  if (dcnt_q == 6'd63) state_d = AL_FIN;
      AL_PBIT: begin
        if (e_q == 64'd0) state_d = AL_FIN;
        else if (e_q[0]) state_d = AL_PMUL;
        else state_d = AL_PSQ;
      end
      AL_PMUL: begin
        if (ph_q == 2'd3) state_d = (e_q[63:1] == 63'd0) ? AL_FIN : AL_PSQ;
      end
      AL_PSQ:  if (ph_q == 2'd3) state_d = AL_PBIT;
      AL_FIN:  state_d = AL_IDLE;
      default: state_d = AL_IDLE;
    endcase
  end

  always_comb begin
    done_o   = (state_q == AL_FIN);
    result_o = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= AL_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      AL_IDLE: begin
        if (start_i) begin
          mx_q     <= a_i;
          my_q     <= (op_i == AO_DIV || op_i == AO_MOD) ? mag(b_i) : b_i;
          ph_q     <= 2'd0;
          quo_q    <= mag(a_i);
          rem_q    <= 64'd0;
          dcnt_q   <= 6'd0;
          neg_q    <= (op_i == AO_DIV) ? (a_i[63] ^ b_i[63]) : a_i[63];
          is_mod_q <= (op_i == AO_MOD);
          r_q      <= 64'd1;
          sq_q     <= a_i;
          e_q      <= b_i;
          res_q    <= 64'd0;
        end
      end
      AL_MUL, AL_PMUL, AL_PSQ: begin
        prod_q <= prod_d;
        ph_q   <= ph_q + 2'd1;
        if (ph_q == 2'd1) acc_q <= prod_q;
        if (ph_q == 2'd2) acc_q <= mul_res;
        if (ph_q == 2'd3) begin
          case (state_q)
            AL_MUL:  res_q <= mul_res;
            AL_PMUL: begin
              r_q   <= mul_res;
              res_q <= mul_res;
              mx_q  <= sq_q;
              my_q  <= sq_q;
            end
            default: begin
              sq_q <= mul_res;
              e_q  <= {1'b0, e_q[63:1]};
            end
          endcase
        end
      end
      AL_PBIT: begin
        ph_q <= 2'd0;
        if (e_q == 64'd0) begin
          res_q <= r_q;
        end else if (e_q[0]) begin
          mx_q <= r_q;
          my_q <= sq_q;
        end else begin
          mx_q <= sq_q;
          my_q <= sq_q;
        end
      end
      AL_DIV: begin
        rem_q  <= rem_n;
        quo_q  <= quo_n;
        dcnt_q <= dcnt_q + 6'd1;
        if (dcnt_q == 6'd63) begin
          if (is_mod_q) res_q <= neg_q ? (64'd0 - rem_n) : rem_n;
          else          res_q <= neg_q ? (64'd0 - quo_n) : quo_n;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

[sv/itsm_dp.sv]
`timescale 1ns / 1ps
// Datapath: stack RAM, depth counter, operand registers, word decode, the
// arithmetic unit and the output register. Depends on itsm_pkg, itsm_ram, itsm_alu.
module itsm_dp
  import itsm_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  localparam int CW = $clog2(STACK_DEPTH + 1),
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cmd_t          cmd_i,
  output sts_t          sts_o,
  input  logic [3:0]    action_i,
  input  logic [63:0]   push_value_i,
  input  logic [1:0]    push_tag_i,
  input  logic          out_stall_i,
  output logic          out_valid_o,
  output logic [2:0]    status_o,
  output logic [63:0]   top_value_o,
  output logic [1:0]    top_tag_o,
  output logic [CW-1:0] depth_o
);

  logic [3:0]    action_q;
  logic [63:0]   pv_q;
  logic [1:0]    ptag_q;
  logic [CW-1:0] cnt_q;
  logic [63:0]   a_val_q, b_val_q;
  logic [1:0]    a_tag_q, b_tag_q;

  logic [2:0]    st_q;
  logic [CW-1:0] ncnt_q;
  logic          w1_en_q, w2_en_q;
  logic [AW-1:0] w1_addr_q, w2_addr_q, pos_q;
  logic [63:0]   w1_val_q, w2_val_q;
  logic [1:0]    w1_tag_q, w2_tag_q;

  logic          out_valid_q;
  logic [2:0]    out_st_q;
  logic [63:0]   out_val_q;
  logic [1:0]    out_tag_q;
  logic [CW-1:0] out_depth_q;

  logic [AW-1:0]     raddr, waddr;
  logic [EntryW-1:0] rdata, wdata;
  logic              we;
  logic [63:0]       alu_res;
  logic              alu_done;

  logic [CW-1:0] nm1, nm2;
  logic          has1, has2, full, ints;
  logic [63:0]   rest64, neg_idx;
  logic [CW-1:0] p_pos;
  logic          p_bad;

  kind_e         p_kind;
  alu_op_e       p_op;
  logic [2:0]    p_st;
  logic [CW-1:0] p_ncnt;
  logic          p_w1_en, p_w2_en;
  logic [AW-1:0] p_w1_addr, p_w2_addr;
  logic [63:0]   p_w1_val, p_w2_val;
  logic [1:0]    p_w1_tag, p_w2_tag;

  assign nm1     = cnt_q - CW'(1);
  assign nm2     = cnt_q - CW'(2);
  assign has1    = cnt_q != '0;
  assign has2    = cnt_q >= CW'(2);
  assign full    = cnt_q >= CW'(STACK_DEPTH);
  assign ints    = (a_tag_q == TAG_INT) && (b_tag_q == TAG_INT);
  assign rest64  = {{(64 - CW){1'b0}}, nm1};
  assign neg_idx = 64'd0 - b_val_q;

  // Index check for get: a negative index counts back from the new top.
  always_comb begin
    if (b_val_q[63]) begin
      p_bad = neg_idx > rest64;
      p_pos = nm1 - neg_idx[CW-1:0];
    end else begin
      p_bad = b_val_q >= rest64;
      p_pos = b_val_q[CW-1:0];
    end
  end

  always_comb begin
    p_kind    = K_PLAIN;
    p_op      = AO_MUL;
    p_st      = ST_OK;
    p_ncnt    = cnt_q;
    p_w1_en   = 1'b0;
    p_w1_addr = cnt_q[AW-1:0];
    p_w1_val  = 64'd0;
    p_w1_tag  = TAG_INT;
    p_w2_en   = 1'b0;
    p_w2_addr = nm2[AW-1:0];
    p_w2_val  = b_val_q;
    p_w2_tag  = b_tag_q;
    case (action_q)
      ACT_PUSH: begin
        if (full) begin
          p_st = ST_OVER;
        end else begin
          p_w1_en  = 1'b1;
          p_w1_tag = ptag_q;
          case (ptag_q)
            TAG_INT:  p_w1_val = pv_q;
            TAG_BOOL: p_w1_val = {63'd0, pv_q != 64'd0};
            default:  p_w1_val = 64'd0;
          endcase
          p_ncnt = cnt_q + CW'(1);
        end
      end
      ACT_DEL: begin
        if (!has1) p_st = ST_UNDER;
        else p_ncnt = nm1;
      end
      ACT_DUP, ACT_UNDER: begin
        if (action_q == ACT_DUP ? !has1 : !has2) begin
          p_st = ST_UNDER;
        end else if (full) begin
          p_st = ST_OVER;
        end else begin
          p_w1_en  = 1'b1;
          p_w1_val = (action_q == ACT_DUP) ? b_val_q : a_val_q;
          p_w1_tag = (action_q == ACT_DUP) ? b_tag_q : a_tag_q;
          p_ncnt   = cnt_q + CW'(1);
        end
      end
      ACT_GET: begin
        if (!has1) begin
          p_st = ST_UNDER;
        end else if (b_tag_q != TAG_INT) begin
          p_st = ST_TYPE;
        end else if (p_bad) begin
          p_st = ST_INDEX;
        end else begin
          p_kind    = K_GET;
          p_w1_en   = 1'b1;
          p_w1_addr = nm1[AW-1:0];
        end
      end
      ACT_SWAP: begin
        if (!has2) begin
          p_st = ST_UNDER;
        end else begin
          p_w1_en   = 1'b1;
          p_w1_addr = nm1[AW-1:0];
          p_w1_val  = a_val_q;
          p_w1_tag  = a_tag_q;
          p_w2_en   = 1'b1;
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_POW, ACT_EQ: begin
        p_w1_addr = nm2[AW-1:0];
        if (!has2) begin
          p_st = ST_UNDER;
        end else if (!ints) begin
          // mod, pow and eq drop their operands on a type error.
          p_st = ST_TYPE;
          if (action_q >= ACT_MOD) p_ncnt = nm2;
        end else if ((action_q == ACT_DIV || action_q == ACT_MOD) &&
                     b_val_q == 64'd0) begin
          p_st = ST_DIVZ;
          if (action_q == ACT_MOD) p_ncnt = nm2;
        end else begin
          p_w1_en = 1'b1;
          p_ncnt  = nm1;
          case (action_q)
            ACT_ADD: p_w1_val = a_val_q + b_val_q;
            ACT_SUB: p_w1_val = a_val_q - b_val_q;
            ACT_EQ: begin
              p_w1_val = {63'd0, a_val_q == b_val_q};
              p_w1_tag = TAG_BOOL;
            end
            ACT_MUL: begin
              p_kind = K_ALU;
              p_op   = AO_MUL;
            end
            ACT_DIV: begin
              p_kind = K_ALU;
              p_op   = AO_DIV;
            end
            ACT_MOD: begin
              p_kind = K_ALU;
              p_op   = AO_MOD;
            end
            default: begin
              p_kind = K_ALU;
              p_op   = AO_POW;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (cmd_i.rsel)
      RS_SECOND: raddr = nm2[AW-1:0];
      RS_POS:    raddr = pos_q;
      default:   raddr = nm1[AW-1:0];
    endcase
    we    = (cmd_i.wr1 && w1_en_q) || (cmd_i.wr2 && w2_en_q);
    waddr = cmd_i.wr2 ? w2_addr_q : w1_addr_q;
    wdata = cmd_i.wr2 ? {w2_tag_q, w2_val_q} : {w1_tag_q, w1_val_q};
  end

  itsm_ram #(
    .WIDTH(EntryW),
    .DEPTH(STACK_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  itsm_alu u_alu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.alu_start),
    .op_i    (p_op),
    .a_i     (a_val_q),
    .b_i     (b_val_q),
    .done_o  (alu_done),
    .result_o(alu_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) cnt_q <= ncnt_q;
      if (cmd_i.out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      action_q <= action_i;
      pv_q     <= push_value_i;
      ptag_q   <= push_tag_i;
    end
    if (cmd_i.cap_b) begin
      b_val_q <= rdata[63:0];
      b_tag_q <= rdata[65:64];
    end
    if (cmd_i.cap_a) begin
      a_val_q <= rdata[63:0];
      a_tag_q <= rdata[65:64];
    end
    if (cmd_i.decide) begin
      st_q      <= p_st;
      ncnt_q    <= p_ncnt;
      w1_en_q   <= p_w1_en;
      w1_addr_q <= p_w1_addr;
      w1_val_q  <= p_w1_val;
      w1_tag_q  <= p_w1_tag;
      w2_en_q   <= p_w2_en;
      w2_addr_q <= p_w2_addr;
      w2_val_q  <= p_w2_val;
      w2_tag_q  <= p_w2_tag;
      pos_q     <= p_pos[AW-1:0];
    end
    if (cmd_i.get_load) begin
      w1_val_q <= rdata[63:0];
      w1_tag_q <= rdata[65:64];
    end
    if (cmd_i.alu_load) begin
      w1_val_q <= alu_res;
    end
    if (cmd_i.out_load) begin
      out_st_q    <= st_q;
      out_val_q   <= has1 ? rdata[63:0] : 64'd0;
      out_tag_q   <= has1 ? rdata[65:64] : TAG_NONE;
      out_depth_q <= cnt_q;
    end
  end

  assign sts_o.kind     = p_kind;
  assign sts_o.alu_done = alu_done;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  assign out_valid_o = out_valid_q;
  assign status_o    = out_st_q;
  assign top_value_o = out_val_q;
  assign top_tag_o   = out_tag_q;
  assign depth_o     = out_depth_q;

endmodule

[sv/itsm_ctrl.sv]
`timescale 1ns / 1ps
// Controller: sequences operand reads, decode, get and arithmetic steps,
// stack writes and the top readback. Depends on itsm_pkg.
module itsm_ctrl
  import itsm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_RDB;
      S_RDB:  state_d = S_RDA;
      S_RDA:  state_d = S_CAPA;
      S_CAPA: state_d = S_DEC;
      S_DEC: begin
        case (sts_i.kind)
          K_GET:   state_d = S_GRD;
          K_ALU:   state_d = S_ALU;
          default: state_d = S_WR1;
        endcase
      end
      S_GRD:  state_d = S_GLD;
      S_GLD:  state_d = S_WR1;
      S_ALU:  if (sts_i.alu_done) state_d = S_WR1;
      S_WR1:  state_d = S_WR2;
      S_WR2:  state_d = S_TRD;
      S_TRD:  state_d = S_TCAP;
      S_TCAP: if (!sts_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.rsel = RS_TOP;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: cmd_o.latch_in = in_valid_i;
      S_RDA: begin
        cmd_o.rsel  = RS_SECOND;
        cmd_o.cap_b = 1'b1;
      end
      S_CAPA: cmd_o.cap_a = 1'b1;
      S_DEC: begin
        cmd_o.decide    = 1'b1;
        cmd_o.alu_start = (sts_i.kind == K_ALU);
      end
      S_GRD:  cmd_o.rsel = RS_POS;
      S_GLD:  cmd_o.get_load = 1'b1;
      S_ALU:  cmd_o.alu_load = sts_i.alu_done;
      S_WR1:  cmd_o.wr1 = 1'b1;
      S_WR2: begin
        cmd_o.wr2    = 1'b1;
        cmd_o.commit = 1'b1;
      end
      S_TCAP: cmd_o.out_load = !sts_i.out_busy;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/tagged_integer_stack_machine.sv]
`timescale 1ns / 1ps
// Top level of the tagged integer stack machine: controller plus datapath.
// Depends on itsm_pkg, itsm_ctrl and itsm_dp.
//
// Each input item carries one stack word (action, push literal and its tag).
// An item is taken at a rising edge with in_valid_i high and in_stall_o low;
// each item yields exactly one result item (status, top entry, depth), taken
// at an edge with out_valid_o high and out_stall_i low.
// The block works on one item at a time. From acceptance to a ready result
// most words pass through two operand reads, decode, two write slots and a
// top readback, all through the single read port of the stack RAM. get adds
// an indexed read. mul uses three 32x32 partial products; div and mod run a
// restoring divider one quotient bit per cycle. pow runs square-and-multiply
// on the same multiplier.
// A finished result sits in an output register, so the next item is taken
// while the receiver stalls; only a second result then waits for the first.
// Reset clears the depth counter, the controller and the output valid; the
// stack RAM is not cleared, since only entries below the depth are read.
module tagged_integer_stack_machine
  import itsm_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [3:0]         action_i,
  input  logic signed [63:0] push_value_i,
  input  logic [1:0]         push_tag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [63:0] top_value_o,
  output logic [1:0]         top_tag_o,
  output logic [CW-1:0]      depth_o
);

  cmd_t cmd;
  sts_t sts;

  // The controller only sequences; all state of the stack lives in the datapath.
  itsm_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  itsm_dp #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .action_i    (action_i),
    .push_value_i(push_value_i),
    .push_tag_i  (push_tag_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_o    (status_o),
    .top_value_o (top_value_o),
    .top_tag_o   (top_tag_o),
    .depth_o     (depth_o)
  );

endmodule

[sv/itsm_check.sv]
`timescale 1ns / 1ps
// Port-level checker for the stack machine and its bind to the top level.
// Depends on itsm_pkg and tagged_integer_stack_machine.
module itsm_check
  import itsm_pkg::*;
#(
  parameter int STACK_DEPTH = 256,
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [3:0]         action_i,
  input logic signed [63:0] push_value_i,
  input logic [1:0]         push_tag_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [2:0]         status_o,
  input logic signed [63:0] top_value_o,
  input logic [1:0]         top_tag_o,
  input logic [CW-1:0]      depth_o
);

  // Only one item is in work at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken while an item is in work");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (depth_o <= CW'(STACK_DEPTH)))
    else $error("depth beyond the stack size");

  a_empty_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && depth_o == '0) |-> (top_value_o == 64'd0 && top_tag_o == TAG_NONE))
    else $error("empty stack shows a top entry");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(status_o) && $stable(top_value_o) && $stable(depth_o)))
    else $error("stalled result changed");

endmodule

bind tagged_integer_stack_machine itsm_check #(.STACK_DEPTH(STACK_DEPTH)) u_check (.*);

[tb/sv/itsm_checker.sv]
`timescale 1ns / 1ps
// Result checker for the tagged integer stack machine: watches both channels,
// predicts each result from its own copy of the stack and compares it.
// Depends on itsm_pkg.
module itsm_checker
  import itsm_pkg::*;
#(
  parameter int STACK_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [3:0]         action_i,
  input  logic signed [63:0] push_value_i,
  input  logic [1:0]         push_tag_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [2:0]         status_i,
  input  logic signed [63:0] top_value_i,
  input  logic [1:0]         top_tag_i,
  input  logic [8:0]         depth_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 seen_o
);

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] value;
    logic [1:0]  tag;
    logic [8:0]  depth;
  } word_result_t;

  logic [63:0] vals[STACK_DEPTH];
  logic [1:0]  tags[STACK_DEPTH];
  int          cnt;
  word_result_t results_q[$];

  assign pending_o = results_q.size();

  function automatic logic [63:0] power_of(logic [63:0] a, logic [63:0] b);
    logic [63:0] r, sq;
    r = 64'd1;
    sq = a;
    if (b[63]) return 64'd0;
    while (b != 0) begin
      if (b[0]) r = r * sq;
      sq = sq * sq;
      b = b >> 1;
    end
    return r;
  endfunction

  // Applies one word to the shadow stack and returns the expected result.
  function automatic word_result_t exec_word(logic [3:0] act, logic [63:0] pv,
                                             logic [1:0] pt);
    word_result_t res;
    logic [2:0]  st;
    logic [63:0] a, b, r, ma, mb, idx, m;
    int          n, pos;
    st = ST_OK;
    n = cnt;
    case (act)
      ACT_PUSH: begin
        if (n >= STACK_DEPTH) st = ST_OVER;
        else begin
          if (pt == TAG_NONE || pt == TAG_WALL) pv = 0;
          else if (pt == TAG_BOOL) pv = (pv != 0) ? 64'd1 : 64'd0;
          vals[n] = pv;
          tags[n] = pt;
          cnt = n + 1;
        end
      end
      ACT_DEL: begin
        if (n < 1) st = ST_UNDER;
        else cnt = n - 1;
      end
      ACT_DUP, ACT_UNDER: begin
        pos = (act == ACT_DUP) ? 1 : 2;
        if (n < pos) st = ST_UNDER;
        else if (n >= STACK_DEPTH) st = ST_OVER;
        else begin
          vals[n] = vals[n-pos];
          tags[n] = tags[n-pos];
          cnt = n + 1;
        end
      end
      ACT_GET: begin
        if (n < 1) st = ST_UNDER;
        else if (tags[n-1] != TAG_INT) st = ST_TYPE;
        else begin
          idx = vals[n-1];
          pos = -1;
          if (idx[63]) begin
            m = -idx;
            if (m <= 64'(n - 1)) pos = (n - 1) - int'(m);
          end else if (idx < 64'(n - 1)) pos = int'(idx);
          if (pos < 0) st = ST_INDEX;
          else begin
            vals[n-1] = vals[pos];
            tags[n-1] = tags[pos];
          end
        end
      end
      ACT_SWAP: begin
        if (n < 2) st = ST_UNDER;
        else begin
          a = vals[n-1];
          vals[n-1] = vals[n-2];
          vals[n-2] = a;
          pt = tags[n-1];
          tags[n-1] = tags[n-2];
          tags[n-2] = pt;
        end
      end
      ACT_ADD, ACT_SUB, ACT_MUL, ACT_DIV, ACT_MOD, ACT_POW, ACT_EQ: begin
        if (n < 2) st = ST_UNDER;
        else if (tags[n-2] != TAG_INT || tags[n-1] != TAG_INT) begin
          st = ST_TYPE;
          if (act >= ACT_MOD) cnt = n - 2;
        end else begin
          a = vals[n-2];
          b = vals[n-1];
          ma = a[63] ? -a : a;
          mb = b[63] ? -b : b;
          pt = TAG_INT;
          r = 0;
          case (act)
            ACT_ADD: r = a + b;
            ACT_SUB: r = a - b;
            ACT_MUL: r = a * b;
            ACT_DIV: begin
              if (b == 0) st = ST_DIVZ;
              else begin
                r = ma / mb;
                if (a[63] ^ b[63]) r = -r;
              end
            end
            ACT_MOD: begin
              if (b == 0) begin
                st = ST_DIVZ;
                cnt = n - 2;
              end else begin
                r = ma % mb;
                if (a[63]) r = -r;
              end
            end
            ACT_POW: r = power_of(a, b);
            default: begin
              r = (a == b) ? 64'd1 : 64'd0;
              pt = TAG_BOOL;
            end
          endcase
          if (st == ST_OK) begin
            vals[n-2] = r;
            tags[n-2] = pt;
            cnt = n - 1;
          end
        end
      end
      default: ;
    endcase
    res.status = st;
    res.value = (cnt > 0) ? vals[cnt-1] : 64'd0;
    res.tag = (cnt > 0) ? tags[cnt-1] : TAG_NONE;
    res.depth = 9'(cnt);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    word_result_t exp_r;
    if (!rst_ni) begin
      cnt = 0;
      results_q.delete();
      fail_count_o <= 0;
      seen_o <= 0;
    end else begin
      if (in_valid_i && !in_stall_i)
        results_q.push_back(exec_word(action_i, push_value_i, push_tag_i));
      if (out_valid_i && !out_stall_i) begin
        seen_o <= seen_o + 1;
        if (results_q.size() == 0) begin
          $error("unexpected result item, status %0d", status_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = results_q.pop_front();
          if (exp_r.status !== status_i || exp_r.value !== top_value_i ||
              exp_r.tag !== top_tag_i || exp_r.depth !== depth_i) begin
            fail_count_o <= fail_count_o + 1;
            if (exp_r.status !== status_i)
              $error("status: expected %0d, got %0d", exp_r.status, status_i);
            if (exp_r.value !== top_value_i)
              $error("top_value: expected %h, got %h", exp_r.value, top_value_i);
            if (exp_r.tag !== top_tag_i)
              $error("top_tag: expected %0d, got %0d", exp_r.tag, top_tag_i);
            if (exp_r.depth !== depth_i)
              $error("depth: expected %0d, got %0d", exp_r.depth, depth_i);
          end
        end
      end
    end
  end

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Top of the stack machine testbench: clock, reset, word stimulus and verdict.
// Depends on itsm_pkg, itsm_checker and tagged_integer_stack_machine.
module tb_top;
  import itsm_pkg::*;

  localparam int Depth = 256;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [3:0]         action_i = '0;
  logic signed [63:0] push_value_i = '0;
  logic [1:0]         push_tag_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [2:0]         status_o;
  logic signed [63:0] top_value_o;
  logic [1:0]         top_tag_o;
  logic [8:0]         depth_o;
  int                 fail_count, pending, seen;
  int                 sent = 0;
  int                 model_depth = 0;  // rough depth, only to steer stimulus

  always #10 clk_i = ~clk_i;

  tagged_integer_stack_machine #(.STACK_DEPTH(Depth)) uut (.*);

  itsm_checker #(.STACK_DEPTH(Depth)) chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .action_i,
    .push_value_i, .push_tag_i, .out_valid_i(out_valid_o), .out_stall_i,
    .status_i(status_o), .top_value_i(top_value_o), .top_tag_i(top_tag_o),
    .depth_i(depth_o), .fail_count_o(fail_count), .pending_o(pending),
    .seen_o(seen)
  );

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 200);
  endfunction

  function automatic logic [63:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 64'h8000000000000000;
      1: return 64'h7fffffffffffffff;
      2: return 64'(signed'($urandom_range(0, 8)) - 4);
      3: return {$urandom, $urandom};
      default: return 64'($urandom_range(0, 40));
    endcase
  endfunction

  // Drives one word and holds it until the block takes it. Valid drops only
  // when a gap follows, so back-to-back words keep it high.
  task automatic send_word(logic [3:0] act, logic [63:0] val, logic [1:0] tag);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    action_i <= act;
    push_value_i <= val;
    push_tag_i <= tag;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
    @(negedge clk_i);
  endtask

  // Receiver stall: random gaps, with stretches of no stall at all.
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(0, 3) == 0) begin
        g = gap_len();
        if (g > 0) begin
          out_stall_i <= 1'b1;
          repeat (g) @(negedge clk_i);
          out_stall_i <= 1'b0;
        end
      end else begin
        repeat ($urandom_range(0, 30)) @(negedge clk_i);
      end
    end
  end

  initial begin
    int act;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: underflow on empty stack, literal normalization, special cases.
    send_word(ACT_DEL, 0, TAG_INT);
    send_word(ACT_ADD, 0, TAG_INT);
    send_word(ACT_GET, 0, TAG_INT);
    send_word(ACT_PUSH, 64'h5, TAG_NONE);
    send_word(ACT_PUSH, 64'hff, TAG_WALL);
    send_word(ACT_PUSH, 64'h8000000000000000, TAG_BOOL);
    send_word(ACT_ADD, 0, TAG_INT);       // type error, operands kept
    send_word(ACT_EQ, 0, TAG_INT);        // type error, operands dropped
    send_word(ACT_PUSH, 64'h8000000000000000, TAG_INT);
    send_word(ACT_PUSH, -64'sd1, TAG_INT);
    send_word(ACT_DIV, 0, TAG_INT);       // most negative over -1
    send_word(ACT_PUSH, -64'sd1, TAG_INT);
    send_word(ACT_UNDER, 0, TAG_INT);
    send_word(ACT_MOD, 0, TAG_INT);
    send_word(ACT_PUSH, 0, TAG_INT);
    send_word(ACT_DIV, 0, TAG_INT);       // zero divisor kept
    send_word(ACT_MOD, 0, TAG_INT);       // zero divisor dropped
    send_word(ACT_PUSH, 3, TAG_INT);
    send_word(ACT_PUSH, -64'sd2, TAG_INT);
    send_word(ACT_POW, 0, TAG_INT);       // negative exponent
    send_word(ACT_PUSH, 0, TAG_INT);
    send_word(ACT_GET, 0, TAG_INT);
    send_word(ACT_PUSH, 64'h7fffffffffffffff, TAG_INT);
    send_word(ACT_GET, 0, TAG_INT);       // bad index
    send_word(4'd14, 0, TAG_INT);         // unused action

    // Fill to overflow and drain back to underflow once.
    repeat (Depth + 2) send_word(ACT_PUSH, rand_value(), 2'($urandom_range(0, 3)));
    send_word(ACT_DUP, 0, TAG_INT);
    send_word(ACT_UNDER, 0, TAG_INT);
    repeat (Depth + 2) send_word(ACT_DEL, 0, TAG_INT);

    // Random: mostly int pushes feeding arithmetic, some noise.
    model_depth = 0;
    repeat (550) begin
      if (model_depth < 2 || $urandom_range(0, 2) == 0) begin
        send_word(ACT_PUSH, rand_value(),
                  ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3)) : TAG_INT);
        model_depth++;
      end else begin
        act = $urandom_range(1, 15);
        if (act == ACT_POW && $urandom_range(0, 1)) begin
          send_word(ACT_PUSH, 64'($urandom_range(0, 70)), TAG_INT);
        end
        send_word(4'(act), rand_value(), 2'($urandom_range(0, 3)));
        if (act >= ACT_ADD && act <= ACT_EQ) model_depth -= 1;
        else if (act == ACT_DEL) model_depth -= 1;
        else if (act == ACT_DUP || act == ACT_UNDER) model_depth += 1;
        if (model_depth < 0) model_depth = 0;
        if (model_depth > 40) repeat (20) send_word(ACT_DEL, 0, TAG_INT);
        if (model_depth > 40) model_depth -= 20;
      end
    end
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
    $display("tb_top: %0d words sent, %0d results checked, including fill to", sent, seen);
    $display("  overflow, drain to underflow and every word type.");
    if (fail_count == 0 && pending == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #120ms;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
